### rtl/smtp_du_pkg.sv
// Shared types, character codes and register indexes of the SMTP DATA dot unstuffer.
package smtp_du_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS   = 1'd1;

  localparam logic [7:0] MAX_HOPS_RESET = 8'd100;

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_DOT = 8'h2e;

  localparam logic [1:0] STAT_DATA    = 2'd0;
  localparam logic [1:0] STAT_END     = 2'd1;
  localparam logic [1:0] STAT_ABORT   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // Position in the line-break / dot-stuffing sequence.
  typedef enum logic [4:0] {
    ST_MID   = 5'b00001,
    ST_LINE  = 5'b00010,
    ST_DOT   = 5'b00100,
    ST_DOTCR = 5'b01000,
    ST_CR    = 5'b10000
  } unstuff_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        last_of_run;
    logic [1:0]  status;
    logic [7:0]  hop_total;
    logic        hops_exceeded;
    logic        size_exceeded;
    logic [31:0] bytes_passed;
  } result_t;

  // Everything one input beat produces: up to three result beats.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic [1:0]      status;
    logic [7:0]      hop_total;
    logic            hops_exceeded;
    logic            size_exceeded;
    logic [31:0]     bytes_passed;
  } bundle_t;

  function automatic logic [7:0] delivered_lower(input logic [3:0] p);
    case (p)
      4'd0:    delivered_lower = "d";
      4'd1:    delivered_lower = "e";
      4'd2:    delivered_lower = "l";
      4'd3:    delivered_lower = "i";
      4'd4:    delivered_lower = "v";
      4'd5:    delivered_lower = "e";
      4'd6:    delivered_lower = "r";
      4'd7:    delivered_lower = "e";
      4'd8:    delivered_lower = "d";
      default: delivered_lower = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] delivered_upper(input logic [3:0] p);
    case (p)
      4'd0:    delivered_upper = "D";
      4'd1:    delivered_upper = "E";
      4'd2:    delivered_upper = "L";
      4'd3:    delivered_upper = "I";
      4'd4:    delivered_upper = "V";
      4'd5:    delivered_upper = "E";
      4'd6:    delivered_upper = "R";
      4'd7:    delivered_upper = "E";
      4'd8:    delivered_upper = "D";
      default: delivered_upper = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] received_lower(input logic [3:0] p);
    case (p)
      4'd0:    received_lower = "r";
      4'd1:    received_lower = "e";
      4'd2:    received_lower = "c";
      4'd3:    received_lower = "e";
      4'd4:    received_lower = "i";
      4'd5:    received_lower = "v";
      4'd6:    received_lower = "e";
      4'd7:    received_lower = "d";
      default: received_lower = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] received_upper(input logic [3:0] p);
    case (p)
      4'd0:    received_upper = "R";
      4'd1:    received_upper = "E";
      4'd2:    received_upper = "C";
      4'd3:    received_upper = "E";
      4'd4:    received_upper = "I";
      4'd5:    received_upper = "V";
      4'd6:    received_upper = "E";
      4'd7:    received_upper = "D";
      default: received_upper = 8'h00;
    endcase
  endfunction

endpackage

### rtl/smtp_data_dot_unstuffer.sv
// SMTP DATA dot unstuffer: removes dot stuffing, finds the end marker and counts header hops.
//
// Each accepted input beat is one raw DATA byte and is handled in the cycle it is accepted:
// its zero to three result beats are formed at once and held in a two-entry result buffer,
// from which they leave one per cycle while result_ready is high. Input beats stream at one
// per cycle while results are taken and no byte yields over one result beat. The rare byte
// that releases a held CR, or a held dot and CR, yields two or three result beats and holds
// the output until all are taken. item_ready drops only while both buffer entries are
// taken. Configuration writes are always taken at once and should be issued only while no
// message byte is in flight.
module smtp_data_dot_unstuffer
  import smtp_du_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Configuration.
  logic [31:0] start_budget;
  logic [7:0]  max_hops;

  // Per-message state.
  unstuff_state_t ustate;
  logic        in_header;
  logic [3:0]  line_position;
  logic        may_be_received;
  logic        may_be_delivered;
  logic        may_be_empty_line;
  logic [7:0]  hop_counter;
  logic [31:0] bytes_until_overflow;
  logic [31:0] byte_counter;
  logic        message_active;
  logic        overflowed;

  unstuff_state_t ustate_next;
  logic        in_header_next;
  logic [3:0]  line_position_next;
  logic        may_be_received_next;
  logic        may_be_delivered_next;
  logic        may_be_empty_line_next;
  logic [7:0]  hop_counter_next;
  logic [31:0] bytes_until_overflow_next;
  logic [31:0] byte_counter_next;
  logic        message_active_next;
  logic        overflowed_next;

  // Result buffer.
  bundle_t    cur;
  bundle_t    pend;
  logic       cur_valid;
  logic       pend_valid;
  logic [1:0] beat_idx;
  bundle_t    bundle_next;

  logic accept;
  logic take;
  logic last_beat;
  logic finish;

  assign cfg_ready  = 1'b1;
  assign item_ready = !pend_valid;
  assign accept     = item_valid && item_ready;

  // The budget counts down from size_limit + 1; zero disables it, all-ones acts as one less.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_budget <= '0;
      max_hops     <= MAX_HOPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_LIMIT: begin
          if (cfg_data == '0) begin
            start_budget <= '0;
          end else if (cfg_data == '1) begin
            start_budget <= '1;
          end else begin
            start_budget <= cfg_data + 32'd1;
          end
        end
        CFG_MAX_HOPS: max_hops <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  ch;
    logic [1:0]  npass;
    logic [1:0]  stat;
    logic [2:0][7:0] obytes;
    logic [32:0] count_sum;

    ch        = item.data_byte;
    npass     = 2'd0;
    stat      = STAT_DATA;
    obytes    = '0;
    count_sum = '0;

    ustate_next               = ustate;
    in_header_next            = in_header;
    line_position_next        = line_position;
    may_be_received_next      = may_be_received;
    may_be_delivered_next     = may_be_delivered;
    may_be_empty_line_next    = may_be_empty_line;
    hop_counter_next          = hop_counter;
    bytes_until_overflow_next = bytes_until_overflow;
    byte_counter_next         = byte_counter;
    message_active_next       = message_active;
    overflowed_next           = overflowed;

    if (item.first_of_message) begin
      ustate_next               = ST_LINE;
      in_header_next            = 1'b1;
      line_position_next        = 4'd0;
      may_be_received_next      = 1'b1;
      may_be_delivered_next     = 1'b1;
      may_be_empty_line_next    = 1'b1;
      hop_counter_next          = 8'd0;
      bytes_until_overflow_next = start_budget;
      byte_counter_next         = 32'd0;
      overflowed_next           = 1'b0;
      message_active_next       = 1'b1;
    end

    if (!message_active_next) begin
      stat = STAT_IGNORED;
    end else begin
      // Header scan: match the line start against both hop keywords and the empty line.
      if (in_header_next) begin
        if (line_position_next < 4'd9) begin
          if (ch != delivered_lower(line_position_next) &&
              ch != delivered_upper(line_position_next)) begin
            may_be_delivered_next = 1'b0;
          end
          if (line_position_next < 4'd8 &&
              ch != received_lower(line_position_next) &&
              ch != received_upper(line_position_next)) begin
            may_be_received_next = 1'b0;
          end
          if ((may_be_delivered_next && line_position_next == 4'd8) ||
              (may_be_received_next && line_position_next == 4'd7)) begin
            if (hop_counter_next != 8'hff) begin
              hop_counter_next = hop_counter_next + 8'd1;
            end
          end
          if ((line_position_next == 4'd0 && ch != CHAR_CR) ||
              (line_position_next == 4'd1 && ch != CHAR_LF)) begin
            may_be_empty_line_next = 1'b0;
          end
          if (may_be_empty_line_next && line_position_next == 4'd1) begin
            in_header_next = 1'b0;
          end
          line_position_next = line_position_next + 4'd1;
        end
        if (ch == CHAR_LF) begin
          line_position_next     = 4'd0;
          may_be_received_next   = 1'b1;
          may_be_delivered_next  = 1'b1;
          may_be_empty_line_next = 1'b1;
        end
      end

      case (ustate_next)
        ST_LINE: begin
          if (ch == CHAR_LF) begin
            stat = STAT_ABORT;
          end else if (ch == CHAR_DOT) begin
            ustate_next = ST_DOT;
          end else if (ch == CHAR_CR) begin
            ustate_next = ST_CR;
          end else begin
            obytes[0]   = ch;
            npass       = 2'd1;
            ustate_next = ST_MID;
          end
        end
        ST_DOT: begin
          if (ch == CHAR_LF) begin
            stat = STAT_ABORT;
          end else if (ch == CHAR_CR) begin
            ustate_next = ST_DOTCR;
          end else begin
            obytes[0]   = ch;
            npass       = 2'd1;
            ustate_next = ST_MID;
          end
        end
        ST_DOTCR: begin
          if (ch == CHAR_LF) begin
            stat = STAT_END;
          end else begin
            // The held dot and CR were not the end marker after all.
            obytes[0] = CHAR_DOT;
            obytes[1] = CHAR_CR;
            if (ch == CHAR_CR) begin
              npass       = 2'd2;
              ustate_next = ST_CR;
            end else begin
              obytes[2]   = ch;
              npass       = 2'd3;
              ustate_next = ST_MID;
            end
          end
        end
        ST_CR: begin
          if (ch == CHAR_LF) begin
            obytes[0]   = CHAR_LF;
            npass       = 2'd1;
            ustate_next = ST_LINE;
          end else if (ch == CHAR_CR) begin
            obytes[0] = CHAR_CR;
            npass     = 2'd1;
          end else begin
            obytes[0]   = CHAR_CR;
            obytes[1]   = ch;
            npass       = 2'd2;
            ustate_next = ST_MID;
          end
        end
        default: begin
          ustate_next = ST_MID;
          if (ch == CHAR_LF) begin
            stat = STAT_ABORT;
          end else if (ch == CHAR_CR) begin
            ustate_next = ST_CR;
          end else begin
            obytes[0] = ch;
            npass     = 2'd1;
          end
        end
      endcase

      if (stat != STAT_DATA) begin
        message_active_next = 1'b0;
      end

      if (bytes_until_overflow_next != '0) begin
        if (bytes_until_overflow_next <= {30'd0, npass}) begin
          bytes_until_overflow_next = '0;
          overflowed_next           = 1'b1;
        end else begin
          bytes_until_overflow_next = bytes_until_overflow_next - {30'd0, npass};
        end
      end
      count_sum         = {1'b0, byte_counter_next} + {31'd0, npass};
      byte_counter_next = count_sum[32] ? '1 : count_sum[31:0];
    end

    bundle_next.bytes         = obytes;
    bundle_next.count         = (stat == STAT_DATA) ? npass : 2'd1;
    bundle_next.status        = stat;
    bundle_next.hop_total     = hop_counter_next;
    bundle_next.hops_exceeded = (hop_counter_next >= max_hops);
    bundle_next.size_exceeded = overflowed_next;
    bundle_next.bytes_passed  = byte_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate               <= ST_LINE;
      in_header            <= 1'b1;
      line_position        <= 4'd0;
      may_be_received      <= 1'b1;
      may_be_delivered     <= 1'b1;
      may_be_empty_line    <= 1'b1;
      hop_counter          <= 8'd0;
      bytes_until_overflow <= '0;
      byte_counter         <= '0;
      message_active       <= 1'b0;
      overflowed           <= 1'b0;
    end else if (accept) begin
      ustate               <= ustate_next;
      in_header            <= in_header_next;
      line_position        <= line_position_next;
      may_be_received      <= may_be_received_next;
      may_be_delivered     <= may_be_delivered_next;
      may_be_empty_line    <= may_be_empty_line_next;
      hop_counter          <= hop_counter_next;
      bytes_until_overflow <= bytes_until_overflow_next;
      byte_counter         <= byte_counter_next;
      message_active       <= message_active_next;
      overflowed           <= overflowed_next;
    end
  end

  assign result_valid = cur_valid;
  assign take         = result_valid && result_ready;
  assign last_beat    = (beat_idx == cur.count - 2'd1);
  assign finish       = take && last_beat;

  assign result.out_byte      = cur.bytes[beat_idx];
  assign result.out_valid     = (cur.status == STAT_DATA);
  assign result.last_of_run   = last_beat;
  assign result.status        = cur.status;
  assign result.hop_total     = cur.hop_total;
  assign result.hops_exceeded = cur.hops_exceeded;
  assign result.size_exceeded = cur.size_exceeded;
  assign result.bytes_passed  = cur.bytes_passed;

  // A swallowed byte has a count of zero and never enters the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      beat_idx   <= 2'd0;
    end else if (!cur_valid || finish) begin
      beat_idx <= 2'd0;
      if (pend_valid) begin
        cur        <= pend;
        cur_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (accept && bundle_next.count != 2'd0) begin
        cur       <= bundle_next;
        cur_valid <= 1'b1;
      end else begin
        cur_valid <= 1'b0;
      end
    end else begin
      if (take) begin
        beat_idx <= beat_idx + 2'd1;
      end
      if (accept && bundle_next.count != 2'd0) begin
        pend       <= bundle_next;
        pend_valid <= 1'b1;
      end
    end
  end

  a_pend_behind_cur: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> cur_valid)
    else $error("second buffer entry is full while the first is empty");

  a_beat_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 2'd0 && beat_idx < cur.count))
    else $error("beat index runs past the buffered result count");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != STAT_DATA) |-> result.last_of_run)
    else $error("end, abort or ignored result is not a single beat");

  a_overflow_counted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.size_exceeded) |-> (result.bytes_passed != '0))
    else $error("size overflow flagged with no bytes passed");

  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(beat_idx)))
    else $error("stalled result beat moved on");

endmodule
